/* rtl/slfr_pkg.sv */
// ----------------------------------------------------------------------------
// Frame receiver package
// Item codes, queue entry type and fixed field widths shared by the block.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BIDX_W   = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = 1;
  localparam int unsigned QCNT_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd34;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd105;

  typedef enum logic [KIND_W-1:0] {
    OP_RX      = 2'd0,
    OP_QUERY   = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_SYNC1 = 4'b0001,
    ST_SYNC2 = 4'b0010,
    ST_LEN   = 4'b0100,
    ST_DATA  = 4'b1000
  } parse_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] rx_byte;
    logic [BIDX_W-1:0] buffer_index;
    logic [BYTE_W-1:0] byte_offset;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

/* rtl/slfr_in_if.sv */
// ----------------------------------------------------------------------------
// Frame receiver input channel
// Valid/ready channel carrying one input item per transfer.
// ----------------------------------------------------------------------------
interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic [1:0] buffer_index;
  logic [7:0] byte_offset;

  modport source (output valid, kind, rx_byte, buffer_index, byte_offset, input ready);
  modport sink   (input valid, kind, rx_byte, buffer_index, byte_offset, output ready);
endinterface

/* rtl/slfr_out_if.sv */
// ----------------------------------------------------------------------------
// Frame receiver result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface slfr_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  ready_index;
  logic [7:0]  frame_length;
  logic [7:0]  data;
  logic        frame_done;
  logic [31:0] frame_count;

  modport source (output valid, found, ready_index, frame_length, data, frame_done,
                  frame_count, input ready);
  modport sink   (input valid, found, ready_index, frame_length, data, frame_done,
                  frame_count, output ready);
endinterface

/* rtl/slfr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module slfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1020
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/slfr_front.sv */
// ----------------------------------------------------------------------------
// Frame receiver front end
// Accepts input items, decodes their kind and holds them in a short queue.
// ----------------------------------------------------------------------------
module slfr_front import slfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  slfr_in_if.sink     in_i,
  input  logic        pop_i,
  output queue_head_t head_o
);

  item_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  item_t             new_item;
  op_e               op;

  always_comb begin
    case (in_i.kind)
      OP_RX:    op = OP_RX;
      OP_QUERY: op = OP_QUERY;
      OP_READ:  op = OP_READ;
      default:  op = OP_RELEASE;
    endcase
  end

  assign new_item = '{op: op, rx_byte: in_i.rx_byte, buffer_index: in_i.buffer_index,
                      byte_offset: in_i.byte_offset};

  assign in_i.ready = (cnt_q != QCNT_W'(QDEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= new_item;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = entry_q[rptr_q];

endmodule

/* rtl/slfr_back.sv */
// ----------------------------------------------------------------------------
// Frame receiver back end
// Runs the frame parser, the buffer pool and the queries, and registers
// each result until it is taken.
// ----------------------------------------------------------------------------
module slfr_back import slfr_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = 4,
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  queue_head_t          head_i,
  output logic                 pop_o,
  slfr_out_if.source           out_o
);

  localparam int unsigned BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned DEPTH  = NUM_BUFFERS * MAX_PAYLOAD;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [BYTE_W-1:0]  sync_first_q, sync_second_q;
  parse_e             state_q, state_d;
  logic [NUM_BUFFERS-1:0] ready_q, ready_d;
  logic [BYTE_W-1:0]  len_q [NUM_BUFFERS];
  logic               len_we;
  logic [BUF_W-1:0]   act_q, act_d;
  logic [BYTE_W-1:0]  fill_q, fill_d, fill_inc;
  logic [COUNT_W-1:0] cnt_q, cnt_d;

  logic               s2_v_q, s2_found_q, s2_found_d, s2_rd_q, s2_rd_d, s2_done_q, s2_done_d;
  logic [BIDX_W-1:0]  s2_index_q, s2_index_d;
  logic [BYTE_W-1:0]  s2_len_q, s2_len_d;

  logic               adv, free_any, ready_any, idx_ok;
  logic [BUF_W-1:0]   free_idx, first_ready;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;
  item_t              it;

  assign it    = head_i.item;
  assign adv   = head_i.valid && (!s2_v_q || out_o.ready);
  assign pop_o = adv;

  always_comb begin
    free_any    = 1'b0;
    free_idx    = '0;
    ready_any   = 1'b0;
    first_ready = '0;
    for (int b = NUM_BUFFERS - 1; b >= 0; b--) begin
      if (!ready_q[b]) begin
        free_any = 1'b1;
        free_idx = BUF_W'(b);
      end
      if (ready_q[b]) begin
        ready_any   = 1'b1;
        first_ready = BUF_W'(b);
      end
    end
  end

  assign idx_ok    = (int'(it.buffer_index) < NUM_BUFFERS);
  assign fill_inc  = fill_q + 1'b1;
  assign ram_waddr = ADDR_W'(int'(act_q) * MAX_PAYLOAD + int'(fill_q));
  assign ram_raddr = ADDR_W'(int'(it.buffer_index) * MAX_PAYLOAD + int'(it.byte_offset));

  always_comb begin
    state_d    = state_q;
    ready_d    = ready_q;
    act_d      = act_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    len_we     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    s2_found_d = 1'b0;
    s2_index_d = '0;
    s2_len_d   = '0;
    s2_rd_d    = 1'b0;
    s2_done_d  = 1'b0;
    if (adv) begin
      case (it.op)
        OP_RX: begin
          case (state_q)
            ST_SYNC1: begin
              if (it.rx_byte == sync_first_q) begin
                state_d = ST_SYNC2;
              end
            end
            ST_SYNC2: begin
              if (it.rx_byte == sync_second_q) begin
                state_d = ST_LEN;
              end
            end
            ST_LEN: begin
              if (it.rx_byte == '0 || int'(it.rx_byte) > MAX_PAYLOAD) begin
                state_d = ST_SYNC2;
              end else if (!free_any) begin
                act_d   = '0;
                state_d = ST_SYNC1;
              end else begin
                act_d   = free_idx;
                len_we  = 1'b1;
                fill_d  = '0;
                state_d = ST_DATA;
              end
            end
            ST_DATA: begin
              ram_we = (int'(fill_q) < MAX_PAYLOAD);
              fill_d = fill_inc;
              if (fill_inc == len_q[act_q]) begin
                ready_d[act_q] = 1'b1;
                state_d        = ST_SYNC1;
                cnt_d          = cnt_q + 1'b1;
                s2_done_d      = 1'b1;
              end
            end
            default: state_d = ST_SYNC1;
          endcase
        end
        OP_QUERY: begin
          s2_found_d = ready_any;
          s2_index_d = ready_any ? BIDX_W'(first_ready) : '0;
          s2_len_d   = ready_any ? len_q[first_ready] : '0;
        end
        OP_READ: begin
          s2_rd_d = idx_ok && (int'(it.byte_offset) < MAX_PAYLOAD);
          ram_re  = s2_rd_d;
        end
        OP_RELEASE: begin
          for (int b = 0; b < NUM_BUFFERS; b++) begin
            if (int'(it.buffer_index) == b) begin
              ready_d[b] = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      state_q       <= ST_SYNC1;
      ready_q       <= '0;
      act_q         <= '0;
      fill_q        <= '0;
      cnt_q         <= '0;
      s2_v_q        <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_SYNC_FIRST) begin
        sync_first_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_SYNC_SECOND) begin
        sync_second_q <= cfg_data_i;
      end
      state_q <= state_d;
      ready_q <= ready_d;
      act_q   <= act_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      if (adv) begin
        s2_v_q <= 1'b1;
      end else if (out_o.ready) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q[free_idx] <= it.rx_byte;
    end
    if (adv) begin
      s2_found_q <= s2_found_d;
      s2_index_q <= s2_index_d;
      s2_len_q   <= s2_len_d;
      s2_rd_q    <= s2_rd_d;
      s2_done_q  <= s2_done_d;
    end
  end

  slfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (it.rx_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The count only moves when a new result is loaded, so it always matches
  // the result on display.
  assign out_o.valid        = s2_v_q;
  assign out_o.found        = s2_found_q;
  assign out_o.ready_index  = s2_index_q;
  assign out_o.frame_length = s2_len_q;
  assign out_o.data         = s2_rd_q ? ram_rdata : '0;
  assign out_o.frame_done   = s2_done_q;
  assign out_o.frame_count  = cnt_q;

  a_fill_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DATA |-> !ready_q[act_q])
    else $error("buffer being filled is marked ready");

  a_done_marks_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_done_d |=> ready_q[$past(act_q)] && cnt_q == $past(cnt_q) + 1'b1)
    else $error("completed frame did not mark its buffer or count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> s2_done_q && s2_v_q)
    else $error("frame counter moved without a completed frame");

endmodule

/* rtl/sync_length_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// Sync and length framed receiver
// Finds two-sync-byte, length-prefixed frames in received bytes, stores
// them in a small buffer pool, and answers queries, reads and releases.
//
//   Channel   Direction  Transfer content
//   in_i      sink       kind, rx_byte, buffer_index, byte_offset
//   out_o     source     found, ready_index, frame_length, data, frame_done,
//                        frame_count
//   cfg_*     write      sync_first (index 0), sync_second (index 1)
//
// One item per cycle is sustained while the result channel is not stalled;
// a result is held in the output register once its item leaves the queue;
// the payload RAM read is registered in the same cycle as the result register.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds in the output register while the queue still takes
// items until it is full.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_core import slfr_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = 4,
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  slfr_in_if.sink              in_i,
  slfr_out_if.source           out_o
);

  queue_head_t head;
  logic        pop;

  slfr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  slfr_back #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
